[rtl/ssc_pkg.sv]
package ssc_pkg;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_MEAS  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // fixed field widths
  localparam int unsigned StepW  = 11;
  localparam int unsigned LevelW = 16;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned ColW   = 7;

  // stored column: signal, noise, squelch mark
  typedef struct packed {
    logic [LevelW-1:0] sig;
    logic [LevelW-1:0] noi;
    logic              mark;
  } column_t;

endpackage

[rtl/ssc_ram.sv]
module ssc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 84
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spectrum_column_capture.sv]
// start and clear: result strobed in the cycle after the transfer, next start taken at once
// read column: the column store read is registered, then the result is registered in ST_READ
// measurement: a one-bit-per-cycle restoring divider of DW bits gives the first column, then
//   columns are written one per cycle (DW = clog2(NUM_COLUMNS+1)+11, 18 at 84 columns)
// reset: step counter 0, steps per scan 1, every column reads as zero until written
// the receiver cannot stall: done_o is high for exactly one cycle per result
module spectrum_column_capture #(
  parameter int unsigned NUM_COLUMNS = 84
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ssc_pkg::cmd_e               cmd_i,
  input  logic [ssc_pkg::LevelW-1:0]  signal_level_i,
  input  logic [ssc_pkg::LevelW-1:0]  noise_level_i,
  input  logic [ssc_pkg::ThrW-1:0]    open_signal_min_i,
  input  logic [ssc_pkg::ThrW-1:0]    close_signal_min_i,
  input  logic [ssc_pkg::ThrW-1:0]    open_noise_max_i,
  input  logic [ssc_pkg::ThrW-1:0]    close_noise_max_i,
  input  logic                        hold_step_i,
  input  logic [ssc_pkg::ColW-1:0]    read_column_i,
  input  logic                        cfg_we_i,
  input  logic [ssc_pkg::StepW-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic                        squelch_open_o,
  output logic [ssc_pkg::ColW-1:0]    first_column_o,
  output logic [ssc_pkg::StepW-1:0]   step_now_o,
  output logic [ssc_pkg::LevelW-1:0]  column_signal_o,
  output logic [ssc_pkg::LevelW-1:0]  column_noise_o,
  output logic                        column_mark_o
);
  import ssc_pkg::*;

  localparam int unsigned AW   = $clog2(NUM_COLUMNS);
  localparam int unsigned NW   = $clog2(NUM_COLUMNS + 1);
  localparam int unsigned DW   = NW + StepW;
  localparam int unsigned CNTW = $clog2(DW);
  localparam int unsigned ACCW = StepW + 1;
  localparam int unsigned CDW  = $bits(column_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_READ
  } state_e;

  state_e               state_q;
  logic [StepW-1:0]     steps_q;
  logic [StepW-1:0]     step_q;
  logic [StepW-1:0]     div_q;
  logic [StepW-1:0]     rem_q;
  logic [DW-1:0]        dvd_q;
  logic [CNTW-1:0]      cnt_q;
  logic [DW-1:0]        col_q;
  logic [ACCW-1:0]      acc_q;
  column_t              wcol_q;
  logic                 hold_q;
  logic                 rd_ok_q;
  logic [NUM_COLUMNS-1:0] valid_q;

  logic                 done_q;
  logic                 open_q;
  logic [ColW-1:0]      first_q;
  logic [LevelW-1:0]    rsig_q;
  logic [LevelW-1:0]    rnoi_q;
  logic                 rmark_q;

  logic                 accept;
  logic                 open_d;
  logic [StepW-1:0]     steps_eff;
  logic [StepW:0]       rem_sh;
  logic                 ge;
  logic [StepW-1:0]     rem_d;
  logic [DW-1:0]        dvd_d;
  logic                 in_run;
  logic                 ram_we;
  column_t              ram_rdata;
  logic [CDW-1:0]       ram_rbits;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // zero steps per scan acts as one
  assign steps_eff = (steps_q == '0) ? StepW'(1) : steps_q;

  // squelch decision
  always_comb begin
    open_d = (signal_level_i > LevelW'(open_signal_min_i)) &&
             (noise_level_i < LevelW'(open_noise_max_i));
    if ((signal_level_i < LevelW'(close_signal_min_i)) ||
        (noise_level_i > LevelW'(close_noise_max_i))) begin
      open_d = 1'b0;
    end
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, dvd_q[DW-1]};
    ge     = (rem_sh >= {1'b0, div_q});
    rem_d  = ge ? StepW'(rem_sh - {1'b0, div_q}) : rem_sh[StepW-1:0];
    dvd_d  = {dvd_q[DW-2:0], ge};
  end

  // column run: stop at the run length or at the end of the store
  assign in_run = (col_q < DW'(NUM_COLUMNS)) && (acc_q < ACCW'(NUM_COLUMNS));
  assign ram_we = (state_q == ST_WRITE) && in_run;

  ssc_ram #(
    .WIDTH (CDW),
    .DEPTH (NUM_COLUMNS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q[AW-1:0]),
    .wdata_i (wcol_q),
    .raddr_i (read_column_i[AW-1:0]),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata = column_t'(ram_rbits);

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      steps_q <= StepW'(1);
      step_q  <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
      open_q  <= 1'b0;
      first_q <= '0;
      rsig_q  <= '0;
      rnoi_q  <= '0;
      rmark_q <= 1'b0;
      div_q   <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      cnt_q   <= '0;
      col_q   <= '0;
      acc_q   <= '0;
      wcol_q  <= '0;
      hold_q  <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        steps_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_i)
              CMD_START, CMD_CLEAR: begin
                step_q  <= '0;
                done_q  <= 1'b1;
                open_q  <= 1'b0;
                first_q <= '0;
                rsig_q  <= '0;
                rnoi_q  <= '0;
                rmark_q <= 1'b0;
                if (cmd_i == CMD_CLEAR) begin
                  valid_q <= '0;
                end
              end
              CMD_MEAS: begin
                wcol_q.sig  <= signal_level_i;
                wcol_q.noi  <= noise_level_i;
                wcol_q.mark <= open_d;
                hold_q      <= hold_step_i;
                div_q       <= steps_eff;
                rem_q       <= '0;
                dvd_q       <= DW'(NUM_COLUMNS) * DW'(step_q);
                cnt_q       <= CNTW'(DW - 1);
                state_q     <= ST_DIV;
              end
              CMD_READ: begin
                rd_ok_q <= ({1'b0, read_column_i} < (ColW + 1)'(NUM_COLUMNS)) &&
                           valid_q[read_column_i[AW-1:0]];
                state_q <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          rem_q <= rem_d;
          dvd_q <= dvd_d;
          cnt_q <= cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            col_q   <= dvd_d;
            acc_q   <= '0;
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (in_run) begin
            valid_q[col_q[AW-1:0]] <= 1'b1;
            col_q <= col_q + DW'(1);
            acc_q <= acc_q + ACCW'(div_q);
          end else begin
            // result of the measurement; first column saturates
            done_q  <= 1'b1;
            open_q  <= wcol_q.mark;
            first_q <= (dvd_q > DW'(127)) ? ColW'(127) : dvd_q[ColW-1:0];
            rsig_q  <= '0;
            rnoi_q  <= '0;
            rmark_q <= 1'b0;
            if (!hold_q) begin
              step_q <= step_q + StepW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          done_q  <= 1'b1;
          open_q  <= 1'b0;
          first_q <= '0;
          rsig_q  <= rd_ok_q ? ram_rdata.sig : '0;
          rnoi_q  <= rd_ok_q ? ram_rdata.noi : '0;
          rmark_q <= rd_ok_q && ram_rdata.mark;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign squelch_open_o  = open_q;
  assign first_column_o  = first_q;
  assign step_now_o      = step_q;
  assign column_signal_o = rsig_q;
  assign column_noise_o  = rnoi_q;
  assign column_mark_o   = rmark_q;

endmodule
